// File: rtl/stl_pkg.sv
// Package: shared types and constants for the slot table.
package stl_pkg;
	localparam logic [18:0] PRICE_MAX = 19'd300000;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_SORT_UP = 3'd4,
		OP_SORT_DN = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		SL_FREE = 2'd0,
		SL_OCC = 2'd1,
		SL_REMOVED = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		RS_OK = 2'd0,
		RS_FULL = 2'd1,
		RS_NOT_FOUND = 2'd2
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SORT_RDI,
		S_SORT_RDJ,
		S_SORT_WAIT,
		S_SORT_CMP,
		S_SORT_WRJ,
		S_DONE
	} state_t;
endpackage

// File: rtl/slot_table_with_id_lookup_and_sort.sv
// Top level: slot table with clear, id lookup, insert, remove and exchange sort.
// Usage:
//   Raise start with opcode, key_id, new_type and new_price_cents while busy is
//   low; the transaction is taken at that edge and busy rises the next cycle.
//   The single result appears on status, slot_index, entry_id, entry_type and
//   entry_price_cents for one cycle with done high; busy falls after it.
//   The receiver cannot stall; results are never held.
// Operations, all served from one memory of depth TABLE_DEPTH with one read port
// and one write port:
//   clear: one status write per cycle.
//   insert, remove, lookup: a read and a check per slot until the first hit.
//   sort: each pair takes a read of j, a wait, a compare that writes slot i on a
//     swap and a write of j on a swap; each row adds a read of i.
//   Opcodes 6 and 7 finish with status ok.
// Reset: asynchronous, clears the control state and the id counter; status of
//   every slot reads as free through a clearing pass after reset, during which
//   busy stays high.
module slot_table_with_id_lookup_and_sort #(
	parameter int TABLE_DEPTH = 64,
	parameter int ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [15:0] key_id,
	input  logic        new_type,
	input  logic [18:0] new_price_cents,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [15:0] entry_id,
	output logic        entry_type,
	output logic [18:0] entry_price_cents
);
	import stl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW:0] LAST = (AW+1)'(TABLE_DEPTH - 1);

	typedef struct packed {
		logic [1:0]         st;
		logic [ID_BITS-1:0] id;
		logic               typ;
		logic [18:0]        price;
	} entry_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	entry_t          wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	state_t state_q, state_d;
	opcode_t op_q;
	logic [15:0] key_q;
	logic        typ_q;
	logic [18:0] price_q;
	logic [ID_BITS-1:0] next_id_q;
	logic [AW:0] i_q, j_q;
	entry_t ei_q, ej_q;
	logic [1:0]  res_st_q;
	logic [5:0]  res_idx_q;
	logic [15:0] res_id_q;
	logic        res_typ_q;
	logic [18:0] res_price_q;
	logic        init_q;

	logic key_hit, ooo;
	assign key_hit = (rd_q.st == SL_OCC) &&
		({{(32-ID_BITS){1'b0}}, rd_q.id} == {16'd0, key_q});
	assign ooo = (ei_q.st == SL_OCC) && (ej_q.st == SL_OCC) &&
		((op_q == OP_SORT_DN) ? (ei_q.id < ej_q.id) : (ei_q.id > ej_q.id));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				case (opcode)
					OP_CLEAR: state_d = S_CLEAR;
					OP_INSERT, OP_REMOVE, OP_LOOKUP: state_d = S_SCAN_RD;
					OP_SORT_UP, OP_SORT_DN: state_d = (TABLE_DEPTH > 1) ? S_SORT_RDI : S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_CLEAR: if (i_q == LAST) state_d = S_DONE;
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if ((op_q == OP_INSERT) ? (rd_q.st == SL_FREE) : key_hit) state_d = S_DONE;
				else if (i_q == LAST) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_SORT_RDI: state_d = S_SORT_RDJ;
			S_SORT_RDJ: state_d = S_SORT_WAIT;
			S_SORT_WAIT: state_d = S_SORT_CMP;
			S_SORT_CMP: begin
				if (ooo) state_d = S_SORT_WRJ;
				else if (j_q != LAST) state_d = S_SORT_RDJ;
				else if (i_q + 1'b1 != LAST) state_d = S_SORT_RDI;
				else state_d = S_DONE;
			end
			S_SORT_WRJ: begin
				if (j_q != LAST) state_d = S_SORT_RDJ;
				else if (i_q + 1'b1 != LAST) state_d = S_SORT_RDI;
				else state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = i_q[AW-1:0];
		raddr = i_q[AW-1:0];
		wdata = rd_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wdata = rd_q;
				wdata.st = SL_FREE;
			end
			S_SCAN_CHK: begin
				if (op_q == OP_INSERT && rd_q.st == SL_FREE) begin
					we = 1'b1;
					wdata.st = SL_OCC;
					wdata.id = next_id_q;
					wdata.typ = typ_q;
					wdata.price = (price_q > PRICE_MAX) ? PRICE_MAX : price_q;
				end else if (op_q == OP_REMOVE && key_hit) begin
					we = 1'b1;
					wdata.st = SL_REMOVED;
				end
			end
			S_SORT_RDJ: raddr = j_q[AW-1:0];
			S_SORT_CMP: begin
				if (ooo) begin
					we = 1'b1;
					wdata = ej_q;
				end
			end
			S_SORT_WRJ: begin
				we = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = ei_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			init_q <= 1'b1;
			i_q <= '0;
			j_q <= '0;
			next_id_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					init_q <= 1'b0;
				end
				S_CLEAR: i_q <= i_q + 1'b1;
				S_SCAN_CHK: begin
					i_q <= i_q + 1'b1;
					if (op_q == OP_INSERT && rd_q.st == SL_FREE)
						next_id_q <= next_id_q + 1'b1;
				end
				S_SORT_RDI: j_q <= i_q + 1'b1;
				S_SORT_CMP, S_SORT_WRJ: begin
					if (!(state_q == S_SORT_CMP && ooo)) begin
						if (j_q != LAST) j_q <= j_q + 1'b1;
						else i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= opcode_t'(opcode);
			key_q <= key_id;
			typ_q <= new_type;
			price_q <= new_price_cents;
			res_st_q <= RS_OK;
			res_idx_q <= '0;
			res_id_q <= '0;
			res_typ_q <= 1'b0;
			res_price_q <= '0;
		end
		if (state_q == S_SORT_RDJ) ei_q <= rd_q;
		if (state_q == S_SORT_WAIT) ej_q <= rd_q;
		if (state_q == S_SCAN_CHK) begin
			if (op_q == OP_INSERT && rd_q.st == SL_FREE) begin
				res_idx_q <= 6'(i_q);
				res_id_q <= 16'(next_id_q);
				res_typ_q <= typ_q;
				res_price_q <= (price_q > PRICE_MAX) ? PRICE_MAX : price_q;
			end else if (op_q != OP_INSERT && key_hit) begin
				res_idx_q <= 6'(i_q);
				res_id_q <= 16'(rd_q.id);
				res_typ_q <= rd_q.typ;
				res_price_q <= rd_q.price;
			end else if (i_q == LAST)
				res_st_q <= (op_q == OP_INSERT) ? RS_FULL : RS_NOT_FOUND;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE) && !init_q;
	assign status = done ? res_st_q : RS_OK;
	assign slot_index = done ? res_idx_q : '0;
	assign entry_id = done ? res_id_q : '0;
	assign entry_type = done ? res_typ_q : 1'b0;
	assign entry_price_cents = done ? res_price_q : '0;

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction not taken");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");
`endif
endmodule
